// File: hdl/dnsle_pkg.sv
package dnsle_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STORE_AW    = 6;

  localparam logic [7:0]  DOT_CHAR  = 8'h2E;
  localparam logic [15:0] CAP_RESET = 16'd512;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_EMPTY_NAME  = 3'd1,
    STAT_EMPTY_LABEL = 3'd2,
    STAT_LABEL_LONG  = 3'd3,
    STAT_NAME_LONG   = 3'd4,
    STAT_NO_ROOM     = 3'd5
  } dnsle_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT_LEN,
    ST_EMIT_DATA,
    ST_TERM
  } dnsle_state_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } emit_t;

endpackage

// File: hdl/dnsle_label_ram.sv
module dnsle_label_ram (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [dnsle_pkg::STORE_AW-1:0]  wr_addr_i,
  input  logic [7:0]                      wr_data_i,
  input  logic                            rd_en_i,
  input  logic [dnsle_pkg::STORE_AW-1:0]  rd_addr_i,
  output logic [7:0]                      rd_data_o
);

  logic [7:0] mem [dnsle_pkg::STORE_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while the consumer is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/dnsle_room_unit.sv
module dnsle_room_unit (
  input  logic [15:0] base_i,
  input  logic [6:0]  addend_i,
  input  logic [15:0] cap_i,
  output logic        fits_o,
  output logic [15:0] sum_o
);

  logic [16:0] sum;

  assign sum    = {1'b0, base_i} + {10'b0, addend_i};
  assign fits_o = sum < {1'b0, cap_i};
  assign sum_o  = sum[15:0];

endmodule

// File: hdl/dnsle_seq.sv
module dnsle_seq #(
  parameter int unsigned MAX_LABEL_CHARS = 63,
  parameter int unsigned MAX_NAME_CHARS  = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_cmd_i,
  input  logic [7:0]                      in_chr_i,
  output logic                            in_stall_o,
  input  logic                            out_free_i,
  output dnsle_pkg::emit_t                emit_o,
  output logic                            wr_en_o,
  output logic [dnsle_pkg::STORE_AW-1:0]  wr_addr_o,
  output logic [7:0]                      wr_data_o,
  output logic                            rd_en_o,
  output logic [dnsle_pkg::STORE_AW-1:0]  rd_addr_o,
  input  logic [7:0]                      rd_data_i,
  output logic [15:0]                     room_base_o,
  output logic [6:0]                      room_addend_o,
  input  logic                            room_fits_i,
  input  logic [15:0]                     room_sum_i
);

  localparam int unsigned AW  = dnsle_pkg::STORE_AW;
  localparam int unsigned NCW = $clog2(MAX_NAME_CHARS + 2);
  localparam logic [NCW-1:0] NAME_MAX  = NCW'(MAX_NAME_CHARS);
  localparam logic [AW:0]    LABEL_MAX = (AW + 1)'(MAX_LABEL_CHARS);

  dnsle_pkg::dnsle_state_e  state_q, state_d;
  dnsle_pkg::dnsle_status_e error_q, error_d;
  logic [AW-1:0]  label_count_q, label_count_d;
  logic           label_sent_q, label_sent_d;
  logic [NCW-1:0] name_count_q, name_count_d;
  logic [15:0]    out_count_q, out_count_d;
  logic [AW-1:0]  n_q, n_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic           end_q, end_d;
  logic           term_chk_q, term_chk_d;

  logic [NCW-1:0] name_inc;
  logic [AW:0]    count_inc;

  assign name_inc  = (name_count_q <= NAME_MAX) ? name_count_q + NCW'(1) : name_count_q;
  assign count_inc = {1'b0, label_count_q} + (AW + 1)'(1);

  assign room_base_o   = out_count_q;
  assign room_addend_o = term_chk_q ? 7'd0 : ({1'b0, n_q} + 7'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dnsle_pkg::ST_IDLE;
      error_q       <= dnsle_pkg::STAT_OK;
      label_count_q <= '0;
      label_sent_q  <= 1'b0;
      name_count_q  <= '0;
      out_count_q   <= '0;
      n_q           <= '0;
      idx_q         <= '0;
      end_q         <= 1'b0;
      term_chk_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      error_q       <= error_d;
      label_count_q <= label_count_d;
      label_sent_q  <= label_sent_d;
      name_count_q  <= name_count_d;
      out_count_q   <= out_count_d;
      n_q           <= n_d;
      idx_q         <= idx_d;
      end_q         <= end_d;
      term_chk_q    <= term_chk_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    error_d       = error_q;
    label_count_d = label_count_q;
    label_sent_d  = label_sent_q;
    name_count_d  = name_count_q;
    out_count_d   = out_count_q;
    n_d           = n_q;
    idx_d         = idx_q;
    end_d         = end_q;
    term_chk_d    = term_chk_q;
    in_stall_o    = 1'b1;
    emit_o        = '0;
    wr_en_o       = 1'b0;
    wr_addr_o     = label_count_q;
    wr_data_o     = in_chr_i;
    rd_en_o       = 1'b0;
    rd_addr_o     = idx_q;

    case (state_q)
      dnsle_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_cmd_i == dnsle_pkg::CMD_END) begin
            end_d = 1'b1;
            if (error_q != dnsle_pkg::STAT_OK) begin
              state_d = dnsle_pkg::ST_TERM;
            end else if (name_count_q == '0) begin
              error_d = dnsle_pkg::STAT_EMPTY_NAME;
              state_d = dnsle_pkg::ST_TERM;
            end else if (label_count_q != '0) begin
              n_d           = label_count_q;
              label_count_d = '0;
              term_chk_d    = 1'b0;
              state_d       = dnsle_pkg::ST_CHECK;
            end else begin
              // only the terminator is left to place
              term_chk_d = 1'b1;
              state_d    = dnsle_pkg::ST_CHECK;
            end
          end else begin
            name_count_d = name_inc;
            end_d        = 1'b0;
            term_chk_d   = 1'b0;
            if (name_inc > NAME_MAX) begin
              error_d = dnsle_pkg::STAT_NAME_LONG;
            end else if (error_q != dnsle_pkg::STAT_OK) begin
              // swallowed after an error
            end else if (in_chr_i == dnsle_pkg::DOT_CHAR) begin
              if (label_sent_q) begin
                label_sent_d  = 1'b0;
                label_count_d = '0;
              end else if (label_count_q == '0) begin
                error_d = dnsle_pkg::STAT_EMPTY_LABEL;
              end else begin
                n_d           = label_count_q;
                label_count_d = '0;
                state_d       = dnsle_pkg::ST_CHECK;
              end
            end else if (label_sent_q) begin
              error_d = dnsle_pkg::STAT_LABEL_LONG;
            end else begin
              wr_en_o = 1'b1;
              if (count_inc >= LABEL_MAX) begin
                // full label goes out straight away
                n_d           = count_inc[AW-1:0];
                label_count_d = '0;
                label_sent_d  = 1'b1;
                state_d       = dnsle_pkg::ST_CHECK;
              end else begin
                label_count_d = count_inc[AW-1:0];
              end
            end
          end
        end
      end

      dnsle_pkg::ST_CHECK: begin
        if (room_fits_i) begin
          if (term_chk_q) begin
            state_d = dnsle_pkg::ST_TERM;
          end else begin
            out_count_d = room_sum_i;
            idx_d       = '0;
            state_d     = dnsle_pkg::ST_EMIT_LEN;
          end
        end else begin
          error_d = dnsle_pkg::STAT_NO_ROOM;
          state_d = end_q ? dnsle_pkg::ST_TERM : dnsle_pkg::ST_IDLE;
        end
      end

      dnsle_pkg::ST_EMIT_LEN: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = {{(8 - AW){1'b0}}, n_q};
          rd_en_o      = 1'b1;
          state_d      = dnsle_pkg::ST_EMIT_DATA;
        end
      end

      dnsle_pkg::ST_EMIT_DATA: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = rd_data_i;
          rd_en_o      = 1'b1;
          rd_addr_o    = idx_q + AW'(1);
          idx_d        = idx_q + AW'(1);
          if (idx_q == n_q - AW'(1)) begin
            state_d = end_q ? dnsle_pkg::ST_TERM : dnsle_pkg::ST_IDLE;
          end
        end
      end

      dnsle_pkg::ST_TERM: begin
        if (out_free_i) begin
          emit_o.valid  = 1'b1;
          emit_o.data   = 8'd0;
          emit_o.last   = 1'b1;
          emit_o.status = error_q;
          error_d       = dnsle_pkg::STAT_OK;
          label_count_d = '0;
          label_sent_d  = 1'b0;
          name_count_d  = '0;
          out_count_d   = '0;
          end_d         = 1'b0;
          term_chk_d    = 1'b0;
          state_d       = dnsle_pkg::ST_IDLE;
        end
      end

      default: state_d = dnsle_pkg::ST_IDLE;
    endcase
  end

  a_bytes_only_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && !emit_o.last) |-> (error_q == dnsle_pkg::STAT_OK))
    else $error("label byte sent with an error recorded");

  a_idx_in_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dnsle_pkg::ST_EMIT_DATA) |-> (idx_q < n_q))
    else $error("read index beyond label length");

  a_label_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, label_count_q} < LABEL_MAX)
    else $error("buffered label reached its limit");

  a_name_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_count_q <= NAME_MAX + NCW'(1))
    else $error("name counter beyond saturation");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dnsle_pkg::ST_TERM && out_free_i) |=>
      (name_count_q == '0 && label_count_q == '0 && out_count_q == '0 &&
       error_q == dnsle_pkg::STAT_OK && state_q == dnsle_pkg::ST_IDLE))
    else $error("name state not cleared after terminator");

endmodule

// File: hdl/dns_name_label_encoder.sv
// character item without output: the next item is taken in the following cycle
// label emit: accept, room check, length byte, characters; output stalls hold the bytes
// end item: with an error or an empty name the terminator follows at once, else after
// a room check and any pending label; the sequencer handles one item at a time
// reset (async, active low) clears all name state and sets cap_q to 512
module dns_name_label_encoder #(
  parameter int unsigned MAX_LABEL_CHARS = 63,
  parameter int unsigned MAX_NAME_CHARS  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_cmd_i,
  input  logic [7:0]  in_chr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [2:0]  out_status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] cap_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [2:0]  out_status_q;
  logic        out_free;

  dnsle_pkg::emit_t emit;
  logic                           wr_en;
  logic [dnsle_pkg::STORE_AW-1:0] wr_addr;
  logic [7:0]                     wr_data;
  logic                           rd_en;
  logic [dnsle_pkg::STORE_AW-1:0] rd_addr;
  logic [7:0]                     rd_data;
  logic [15:0]                    room_base;
  logic [6:0]                     room_addend;
  logic                           room_fits;
  logic [15:0]                    room_sum;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= dnsle_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_byte_q   <= emit.data;
      out_last_q   <= emit.last;
      out_status_q <= emit.status;
    end
  end

  dnsle_seq #(
    .MAX_LABEL_CHARS (MAX_LABEL_CHARS),
    .MAX_NAME_CHARS  (MAX_NAME_CHARS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_cmd_i      (in_cmd_i),
    .in_chr_i      (in_chr_i),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .room_base_o   (room_base),
    .room_addend_o (room_addend),
    .room_fits_i   (room_fits),
    .room_sum_i    (room_sum)
  );

  dnsle_label_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dnsle_room_unit u_room (
    .base_i   (room_base),
    .addend_i (room_addend),
    .cap_i    (cap_q),
    .fits_o   (room_fits),
    .sum_o    (room_sum)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

// File: test/dns_name_label_encoder_test.sv
module dns_name_label_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LABEL     = 63;
  localparam int unsigned MAX_NAME      = 255;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 50000;
  localparam int unsigned PHASE_ITEMS   = 6;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } wire_byte_t;

  class name_encoding_board;
    wire_byte_t               due[$];
    logic [7:0]               label_chars[64];
    int unsigned              label_len;
    bit                       label_flushed;
    int unsigned              name_len;
    int unsigned              bytes_out;
    int unsigned              capacity;
    dnsle_pkg::dnsle_status_e err;
    int                       failures;

    function new();
      capacity = dnsle_pkg::CAP_RESET;
      failures = 0;
      clear_name();
    endfunction

    function void clear_name();
      foreach (label_chars[i]) label_chars[i] = 8'h00;
      label_len     = 0;
      label_flushed = 1'b0;
      name_len      = 0;
      bytes_out     = 0;
      err           = dnsle_pkg::STAT_OK;
    endfunction

    function void push_byte(logic [7:0] data, logic last, logic [2:0] status);
      wire_byte_t b;
      b.data   = data;
      b.last   = last;
      b.status = status;
      due.push_back(b);
    endfunction

    // length byte then the buffered characters, provided the label fits
    function void emit_label();
      if (bytes_out + label_len + 1 >= capacity) begin
        err = dnsle_pkg::STAT_NO_ROOM;
        return;
      end
      push_byte(label_len[7:0], 1'b0, dnsle_pkg::STAT_OK);
      for (int i = 0; i < label_len; i++) begin
        push_byte(label_chars[i & 63], 1'b0, dnsle_pkg::STAT_OK);
      end
      bytes_out = (bytes_out + label_len + 1) & 32'hFFFF;
    endfunction

    function void take_item(logic cmd, logic [7:0] chr);
      if (cmd == dnsle_pkg::CMD_END) begin
        if (err == dnsle_pkg::STAT_OK) begin
          if (name_len == 0) err = dnsle_pkg::STAT_EMPTY_NAME;
          else if (label_len > 0) emit_label();
        end
        if (err == dnsle_pkg::STAT_OK && bytes_out >= capacity) err = dnsle_pkg::STAT_NO_ROOM;
        push_byte(8'h00, 1'b1, err);
        clear_name();
        return;
      end
      if (name_len <= MAX_NAME) name_len++;
      // name too long overrides whatever went wrong earlier
      if (name_len > MAX_NAME) begin
        err = dnsle_pkg::STAT_NAME_LONG;
        return;
      end
      if (err != dnsle_pkg::STAT_OK) return;
      if (chr == dnsle_pkg::DOT_CHAR) begin
        if (label_flushed) begin
          label_flushed = 1'b0;
          label_len     = 0;
        end else if (label_len == 0) begin
          err = dnsle_pkg::STAT_EMPTY_LABEL;
        end else begin
          emit_label();
          label_len = 0;
        end
        return;
      end
      if (label_flushed) begin
        err = dnsle_pkg::STAT_LABEL_LONG;
        return;
      end
      label_chars[label_len & 63] = chr;
      label_len++;
      if (label_len >= MAX_LABEL) begin
        emit_label();
        label_len     = 0;
        label_flushed = 1'b1;
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic [2:0] status);
      wire_byte_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected output, expected nothing, got %02h last %0d status %0d",
                 $time, data, last, status);
        failures++;
        return;
      end
      want = due.pop_front();
      if (want.data !== data || want.last !== last || want.status !== status) begin
        $display("%0t: output mismatch, expected %02h last %0d status %0d,",
                 $time, want.data, want.last, want.status,
                 " got %02h last %0d status %0d", data, last, status);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        in_cmd_i = dnsle_pkg::CMD_CHAR;
  logic [7:0]  in_chr_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic [2:0]  out_status_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;

  name_encoding_board board = new();
  bit                 calm = 1'b0;
  int unsigned        items_sent = 0;
  int unsigned        cycle_count = 0;

  dns_name_label_encoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_cmd_i     (in_cmd_i),
    .in_chr_i     (in_chr_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_status_o (out_status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_byte(out_byte_o, out_last_o, out_status_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d output items outstanding", $time, board.due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic cmd, input logic [7:0] chr);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_cmd_i   = cmd;
    in_chr_i   = chr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_item(cmd, chr);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 254));
    if (c >= dnsle_pkg::DOT_CHAR) c = c + 8'd1;
    return c;
  endfunction

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(dnsle_pkg::CMD_CHAR, s[i]);
  endtask

  task automatic send_label(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(dnsle_pkg::CMD_CHAR, plain_char());
  endtask

  task automatic end_name();
    send_item(dnsle_pkg::CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i       = 1'b0;
    board.capacity = value;
  endtask

  task automatic send_random_name();
    int unsigned kind;
    int unsigned labels;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      labels = $urandom_range(1, 3);
      for (int unsigned i = 0; i < labels; i++) begin
        if (i != 0) send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
        send_label($urandom_range(1, 6));
      end
      if ($urandom_range(0, 3) == 0) send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
    end else if (kind < 80) begin
      n = $urandom_range(0, 8);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
        else send_item(dnsle_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
      end
    end else if (kind < 90) begin
      // empty label: two dots in a row, sometimes after a leading dot
      if ($urandom_range(0, 1) != 0) send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
      send_label($urandom_range(1, 5));
      send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
      send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
      send_label($urandom_range(0, 4));
    end else if (kind < 95) begin
      send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
    end
    end_name();
  endtask

  initial begin
    logic [15:0] caps[8];
    int unsigned phase_start;
    caps = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd9, 16'd24, 16'd300};
    caps[5] = 16'($urandom_range(4, 40));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed names at the reset capacity
    end_name();
    send_text("a");
    end_name();
    send_text("ab.c.");
    end_name();
    send_text(".a");
    end_name();
    send_text("a..b");
    end_name();
    send_item(dnsle_pkg::CMD_CHAR, 8'h00);
    send_item(dnsle_pkg::CMD_CHAR, 8'hFF);
    send_item(dnsle_pkg::CMD_CHAR, 8'h7F);
    end_name();

    // full label followed by a dot and a short label
    send_label(MAX_LABEL);
    send_item(dnsle_pkg::CMD_CHAR, dnsle_pkg::DOT_CHAR);
    send_text("b");
    end_name();

    for (int phase = 0; phase < 8; phase++) begin
      write_capacity(caps[phase]);
      calm = (phase == 6);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_name();
    end
    calm = 1'b0;

    drain();
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/dnsle_pkg.sv
hdl/dnsle_label_ram.sv
hdl/dnsle_room_unit.sv
hdl/dnsle_seq.sv
hdl/dns_name_label_encoder.sv
test/dns_name_label_encoder_test.sv
